// File: rtl/core/cscan_pkg.sv
// shared constants and types for the c-scan request scheduler
package cscan_pkg;

  localparam int MAX_REQUESTS  = 32;
  localparam int CYLINDER_BITS = 16;
  localparam int CYL_W         = 16;
  localparam int SEEK_W        = 18;
  localparam int IDX_W         = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W         = $clog2(MAX_REQUESTS + 1);
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [CYL_W-1:0]  CYL_MASK  = (CYLINDER_BITS >= CYL_W) ? {CYL_W{1'b1}} :
                                            CYL_W'((1 << CYLINDER_BITS) - 1);
  localparam logic [CYL_W-1:0]  TOP_RESET = CYL_W'(199);
  localparam logic [SEEK_W-1:0] SEEK_MAX  = {SEEK_W{1'b1}};

  // register select is paddr bit 2
  localparam logic REG_START = 1'b0;
  localparam logic REG_TOP   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_I,
    ST_SORT_V,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_RD_A,
    ST_EV_A,
    ST_TOP,
    ST_ZERO,
    ST_RD_B,
    ST_EV_B
  } state_t;

  typedef enum logic [1:0] {
    RA_I,
    RA_IM1,
    RA_JM2,
    RA_K
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    sort_init;
    rd_sel_t rd_sel;
    logic    latch_v;
    logic    shift;
    logic    put_v;
    logic    scan_init;
    logic    count_low;
    logic    k_inc;
    logic    k_clr;
    logic    emit_entry;
    logic    emit_top;
    logic    emit_zero;
    logic    last;
    logic    finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic i_done;
    logic j_is_one;
    logic gt;
    logic ge_start;
    logic k_last_a;
    logic k_last_b;
    logic low_seen;
  } dp_status_t;

endpackage

// File: rtl/core/cscan_dp.sv
// request store, sort and scan counters, seek accumulator and result registers
module cscan_dp import cscan_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  input  logic [CYL_W-1:0]  cylinder,
  input  logic [CYL_W-1:0]  start_cylinder,
  input  logic [CYL_W-1:0]  top_cylinder,
  output dp_status_t        status,
  output logic              result_valid,
  output logic [CYL_W-1:0]  position,
  output logic [SEEK_W-1:0] seek_total,
  output logic              boundary_move,
  output logic              overflow,
  output logic              last_of_run
);

  logic [CYL_W-1:0]  mem [MAX_REQUESTS];
  logic [CYL_W-1:0]  rdata;
  logic [CYL_W-1:0]  v;
  logic [CNT_W-1:0]  i;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  k;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  split;
  logic [CYL_W-1:0]  head;
  logic [SEEK_W-1:0] seek;
  logic              dropped;

  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  logic [CYL_W-1:0]  wdata;
  logic              we;
  logic              has_room;
  logic              emit;
  logic [CYL_W-1:0]  target;
  logic [CYL_W-1:0]  move_len;
  logic [SEEK_W:0]   seek_sum;
  logic [SEEK_W-1:0] seek_sat;

  assign has_room = count < CNT_W'(MAX_REQUESTS);
  assign emit     = cmd.emit_entry | cmd.emit_top | cmd.emit_zero;

  always_comb begin
    unique case (cmd.rd_sel)
      RA_I:    raddr = i[IDX_W-1:0];
      RA_IM1:  raddr = IDX_W'(i - CNT_W'(1));
      RA_JM2:  raddr = j - IDX_W'(2);
      RA_K:    raddr = k;
      default: raddr = k;
    endcase
  end

  // one write a cycle: load, sort shift or insert
  always_comb begin
    we    = 1'b0;
    waddr = j;
    wdata = v;
    priority if (cmd.load) begin
      we    = has_room;
      waddr = count[IDX_W-1:0];
      wdata = cylinder & CYL_MASK;
    end else if (cmd.shift) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (cmd.put_v) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    priority if (cmd.emit_top) begin
      target = top_cylinder;
    end else if (cmd.emit_zero) begin
      target = '0;
    end else begin
      target = rdata;
    end
  end

  assign move_len = (head > target) ? head - target : target - head;
  assign seek_sum = {1'b0, seek} + (SEEK_W + 1)'(move_len);
  assign seek_sat = seek_sum[SEEK_W] ? SEEK_MAX : seek_sum[SEEK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      dropped      <= 1'b0;
      i            <= '0;
      j            <= '0;
      k            <= '0;
      split        <= '0;
      head         <= '0;
      seek         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
      if (cmd.load) begin
        if (has_room) begin
          count <= count + CNT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.sort_init) begin
        i <= CNT_W'(1);
      end
      if (cmd.latch_v) begin
        j <= i[IDX_W-1:0];
      end
      if (cmd.shift) begin
        j <= j - IDX_W'(1);
      end
      if (cmd.put_v) begin
        i <= i + CNT_W'(1);
      end
      if (cmd.scan_init) begin
        k     <= '0;
        split <= '0;
        head  <= start_cylinder;
        seek  <= '0;
      end
      if (cmd.count_low) begin
        split <= split + CNT_W'(1);
      end
      if (cmd.k_inc) begin
        k <= k + IDX_W'(1);
      end
      if (cmd.k_clr) begin
        k <= '0;
      end
      // the last move of a batch clears the running total
      if (emit) begin
        head <= target;
        seek <= cmd.finish ? '0 : seek_sat;
      end
      // end of batch: head keeps its place
      if (cmd.finish) begin
        count   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_v) begin
      v <= rdata;
    end
    if (emit) begin
      position      <= target;
      seek_total    <= seek_sat;
      boundary_move <= cmd.emit_top | cmd.emit_zero;
      overflow      <= dropped;
      last_of_run   <= cmd.last;
    end
  end

  assign status.i_done   = i >= count;
  assign status.j_is_one = j == IDX_W'(1);
  assign status.gt       = rdata > v;
  assign status.ge_start = rdata >= start_cylinder;
  assign status.k_last_a = CNT_W'(k) == count - CNT_W'(1);
  assign status.k_last_b = CNT_W'(k) == split - CNT_W'(1);
  assign status.low_seen = split != '0;

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_REQUESTS))
    else $error("request count above store depth");

  a_split_in_count: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_entry |-> split <= count)
    else $error("low request count above batch size");

endmodule

// File: rtl/core/cscan_ctrl.sv
// sequencer for loading, insertion sort and the two scan passes
module cscan_ctrl import cscan_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       final_request,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && final_request) begin
          state_next = ST_SORT_I;
        end
      end
      ST_SORT_I: begin
        state_next = status.i_done ? ST_RD_A : ST_SORT_V;
      end
      ST_SORT_V: begin
        state_next = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        if (!status.gt) begin
          state_next = ST_SORT_I;
        end else if (status.j_is_one) begin
          state_next = ST_SORT_PUT;
        end
      end
      ST_SORT_PUT: begin
        state_next = ST_SORT_I;
      end
      ST_RD_A: begin
        state_next = ST_EV_A;
      end
      ST_EV_A: begin
        if (!status.k_last_a) begin
          state_next = ST_RD_A;
        end else if (!status.ge_start || status.low_seen) begin
          state_next = ST_TOP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_TOP: begin
        state_next = ST_ZERO;
      end
      ST_ZERO: begin
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        state_next = ST_EV_B;
      end
      ST_EV_B: begin
        state_next = status.k_last_b ? ST_IDLE : ST_RD_B;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RA_K;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.load      = start;
        cmd.sort_init = start && final_request;
      end
      ST_SORT_I: begin
        cmd.rd_sel    = RA_I;
        cmd.scan_init = status.i_done;
      end
      ST_SORT_V: begin
        cmd.latch_v = 1'b1;
        cmd.rd_sel  = RA_IM1;
      end
      ST_SORT_CMP: begin
        if (status.gt) begin
          cmd.shift  = 1'b1;
          cmd.rd_sel = RA_JM2;
        end else begin
          cmd.put_v = 1'b1;
        end
      end
      ST_SORT_PUT: begin
        cmd.put_v = 1'b1;
      end
      ST_RD_A: begin
        cmd.rd_sel = RA_K;
      end
      ST_EV_A: begin
        // sorted store: every low request comes before the first emitted one
        cmd.emit_entry = status.ge_start;
        cmd.count_low  = !status.ge_start;
        cmd.last       = status.k_last_a && !status.low_seen;
        cmd.k_inc      = !status.k_last_a;
        cmd.finish     = status.k_last_a && status.ge_start && !status.low_seen;
      end
      ST_TOP: begin
        cmd.emit_top = 1'b1;
        cmd.k_clr    = 1'b1;
      end
      ST_ZERO: begin
        cmd.emit_zero = 1'b1;
      end
      ST_RD_B: begin
        cmd.rd_sel = RA_K;
      end
      ST_EV_B: begin
        cmd.emit_entry = 1'b1;
        cmd.last       = status.k_last_b;
        cmd.k_inc      = !status.k_last_b;
        cmd.finish     = status.k_last_b;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  a_put_after_cmp: assert property (@(posedge clk) disable iff (rst)
    state == ST_SORT_PUT |-> $past(state) == ST_SORT_CMP)
    else $error("insert at slot zero without a shift before it");

  a_wrap_after_top: assert property (@(posedge clk) disable iff (rst)
    state == ST_TOP |=> state == ST_ZERO)
    else $error("top edge move not followed by the wrap");

endmodule

// File: rtl/core/cscan_disk_request_scheduler.sv
// c-scan scheduler top: register port, sequencer and datapath
// loading: one request per cycle, busy stays low until the final request
// sort: insertion sort over the one-read-port store, states SORT_I, SORT_V and SORT_CMP per request
// service: upper pass reads each stored request (RD_A, EV_A); top, wrap and low ones (RD_B, EV_B) follow
// each result strobes one cycle; top and wrap come back to back
// sync reset clears counts, flags, head, seek and registers (start 0, top 199); store not cleared
module cscan_disk_request_scheduler import cscan_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CYL_W-1:0]  cylinder,
  input  logic              final_request,
  output logic              result_valid,
  output logic [CYL_W-1:0]  position,
  output logic [SEEK_W-1:0] seek_total,
  output logic              boundary_move,
  output logic              overflow,
  output logic              last_of_run,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CYL_W-1:0] start_cylinder;
  logic [CYL_W-1:0] top_cylinder;
  logic             reg_wr;
  ctrl_cmd_t        cmd;
  dp_status_t       status;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cylinder <= '0;
      top_cylinder   <= TOP_RESET;
    end else if (reg_wr) begin
      unique case (paddr[2])
        REG_START: start_cylinder <= pwdata[CYL_W-1:0];
        REG_TOP:   top_cylinder   <= pwdata[CYL_W-1:0];
        default:   start_cylinder <= start_cylinder;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_START: prdata = DATA_W'(start_cylinder);
      REG_TOP:   prdata = DATA_W'(top_cylinder);
      default:   prdata = '0;
    endcase
  end

  cscan_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .final_request (final_request),
    .status        (status),
    .cmd           (cmd),
    .busy          (busy)
  );

  cscan_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cylinder       (cylinder),
    .start_cylinder (start_cylinder),
    .top_cylinder   (top_cylinder),
    .status         (status),
    .result_valid   (result_valid),
    .position       (position),
    .seek_total     (seek_total),
    .boundary_move  (boundary_move),
    .overflow       (overflow),
    .last_of_run    (last_of_run)
  );

  a_mid_run_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |-> busy)
    else $error("block idle while a batch is still being served");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_run |=> !result_valid)
    else $error("item after the last position of a batch");

endmodule
